// File: rtl/luinv_pkg.sv
package luinv_pkg;

  // Width of the size register and the fixed-point words
  localparam int unsigned SIZE_W = 4;
  localparam int unsigned DATA_W = 32;

  // Status codes on the result port
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SATURATE = 2'd2;

  // Q16.16 one
  localparam logic [DATA_W-1:0] ONE_Q = 32'h0001_0000;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_t;

  // Clamp a 49-bit signed difference to 32 bits
  function automatic sat_t sat49(input logic signed [48:0] v);
    sat_t r;
    if (v > 49'sh0_7FFF_FFFF) begin
      r.ovf = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else if (v < -49'sh0_8000_0000) begin
      r.ovf = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/luinv_ram.sv
module luinv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/lup_matrix_inverse.sv
// Run: after the last element of an n x n matrix, elimination, n column solves and
//   readout follow; the shared radix-2 divider dominates run time. Results come row-major.
// Throughput: one run at a time; start is taken one element per cycle while idle.
// Reset: asynchronous, active low; size returns to MAX_DIM, load count and
//   saturation flag clear. Results cannot be stalled by the receiver.
module lup_matrix_inverse
  import luinv_pkg::*;
#(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [SIZE_W-1:0]        cfg_wdata_i,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] element_value_i,
  output logic                     result_valid_o,
  output logic signed [DATA_W-1:0] inverse_value_o,
  output logic [1:0]               status_o,
  output logic                     last_of_run_o
);

  localparam int unsigned AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned MAW   = 2 * AW;
  localparam int unsigned MDEP  = 1 << MAW;
  localparam int unsigned STEPS = 48;

  // Sequencer codes
  localparam logic [5:0] S_IDLE = 6'd0,  S_INIT = 6'd1,  S_PVA  = 6'd2,  S_PVB  = 6'd3;
  localparam logic [5:0] S_PVE  = 6'd4,  S_RS0  = 6'd5,  S_RS1  = 6'd6,  S_SW0  = 6'd7;
  localparam logic [5:0] S_SW1  = 6'd8,  S_SW2  = 6'd9,  S_SW3  = 6'd10, S_EL0  = 6'd11;
  localparam logic [5:0] S_EL1  = 6'd12, S_EL2  = 6'd13, S_EL3  = 6'd14, S_UP0  = 6'd15;
  localparam logic [5:0] S_UP1  = 6'd16, S_UP2  = 6'd17, S_ELN  = 6'd18, S_DG0  = 6'd19;
  localparam logic [5:0] S_DG1  = 6'd20, S_FW0  = 6'd21, S_FW1  = 6'd22, S_FW2  = 6'd23;
  localparam logic [5:0] S_FW3  = 6'd24, S_BK0  = 6'd25, S_BK1  = 6'd26, S_BK2  = 6'd27;
  localparam logic [5:0] S_BK3  = 6'd28, S_BK4  = 6'd29, S_BK5  = 6'd30, S_DIV  = 6'd31;
  localparam logic [5:0] S_DFIN = 6'd32, S_OUT0 = 6'd33, S_OUT1 = 6'd34, S_SING = 6'd35;

  function automatic logic [MAW-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return {r[AW-1:0], c[AW-1:0]};
  endfunction

  // Control registers
  logic [5:0]        state_q, state_d, ret_q, ret_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [CW-1:0]     ldr_q, ldr_d, ldc_q, ldc_d;
  logic              ovf_q, ovf_d;

  // Working registers
  logic [CW-1:0]     k_q, k_d, i_q, i_d, j_q, j_d, p_q, p_d;
  logic [DATA_W-1:0] best_q, best_d, tmp_q, tmp_d, lq_q, lq_d, acc_q, acc_d, qres_q, qres_d;
  logic [AW-1:0]     rtmp_q, rtmp_d;
  logic [AW-1:0]     rord_q [MAX_DIM];
  logic [AW-1:0]     rord_d [MAX_DIM];
  logic [DATA_W-1:0] fv_q [MAX_DIM];
  logic [DATA_W-1:0] fv_d [MAX_DIM];
  logic [47:0]       dvd_q, dvd_d;
  logic [32:0]       rem_q, rem_d;
  logic [DATA_W-1:0] dsr_q, dsr_d;
  logic              dneg_q, dneg_d;
  logic [5:0]        dcnt_q, dcnt_d;
  logic signed [63:0] prod_q, prod_d;

  // Memory ports
  logic              wm_we, iv_we;
  logic [MAW-1:0]    wm_wa, wm_ra, iv_wa, iv_ra;
  logic [DATA_W-1:0] wm_wd, iv_wd, wm_rd, iv_rd;

  // Shared datapath nets
  logic [CW-1:0]      n_eff;
  logic signed [31:0] mul_a, mul_b;
  logic [DATA_W-1:0]  sub_a, mag_rd, div_a, div_b;
  logic signed [48:0] diff;
  sat_t               sat_r;
  logic [32:0]        trial;
  logic               div_go;

  luinv_ram #(.WIDTH(DATA_W), .DEPTH(MDEP)) u_work (
    .clk_i, .we_i(wm_we), .waddr_i(wm_wa), .wdata_i(wm_wd), .raddr_i(wm_ra), .rdata_o(wm_rd)
  );

  luinv_ram #(.WIDTH(DATA_W), .DEPTH(MDEP)) u_inv (
    .clk_i, .we_i(iv_we), .waddr_i(iv_wa), .wdata_i(iv_wd), .raddr_i(iv_ra), .rdata_o(iv_rd)
  );

  // Effective size: zero acts as one, large values clamp
  always_comb begin
    if (size_q == '0) begin
      n_eff = CW'(1);
    end else if (size_q > SIZE_W'(MAX_DIM)) begin
      n_eff = CW'(MAX_DIM);
    end else begin
      n_eff = CW'(size_q);
    end
  end

  // Shared multiplier, saturating subtract, pivot magnitude and divider trial
  always_comb begin
    case (state_q)
      S_UP1:   begin mul_a = lq_q;  mul_b = wm_rd; end
      S_FW2:   begin mul_a = wm_rd; mul_b = fv_q[j_q[AW-1:0]]; end
      default: begin mul_a = wm_rd; mul_b = iv_rd; end
    endcase
    prod_d = mul_a * mul_b;
    sub_a  = (state_q == S_UP2) ? wm_rd : acc_q;
    diff   = {{17{sub_a[31]}}, sub_a} - {prod_q[63], prod_q[63:16]};
    sat_r  = sat49(diff);
    mag_rd = wm_rd[31] ? (~wm_rd + 32'd1) : wm_rd;
    trial  = {rem_q[31:0], dvd_q[47]};
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    size_d  = size_q;
    ldr_d   = ldr_q;
    ldc_d   = ldc_q;
    ovf_d   = ovf_q;
    k_d     = k_q;
    i_d     = i_q;
    j_d     = j_q;
    p_d     = p_q;
    best_d  = best_q;
    tmp_d   = tmp_q;
    lq_d    = lq_q;
    acc_d   = acc_q;
    qres_d  = qres_q;
    rtmp_d  = rtmp_q;
    rord_d  = rord_q;
    fv_d    = fv_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    dneg_d  = dneg_q;
    dcnt_d  = dcnt_q;
    wm_we   = 1'b0;
    wm_wa   = addr(i_q, j_q);
    wm_wd   = sat_r.val;
    wm_ra   = addr(i_q, j_q);
    iv_we   = 1'b0;
    iv_wa   = addr(i_q, k_q);
    iv_wd   = qres_q;
    iv_ra   = addr(i_q, j_q);
    div_go  = 1'b0;
    div_a   = tmp_q;
    div_b   = wm_rd;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (ldr_q == '0 && ldc_q == '0) begin
            ovf_d = 1'b0;
          end
          wm_we = 1'b1;
          wm_wa = addr(ldr_q, ldc_q);
          wm_wd = element_value_i;
          if (ldc_q + CW'(1) == n_eff) begin
            ldc_d = '0;
            if (ldr_q + CW'(1) == n_eff) begin
              ldr_d   = '0;
              state_d = S_INIT;
            end else begin
              ldr_d = ldr_q + CW'(1);
            end
          end else begin
            ldc_d = ldc_q + CW'(1);
          end
        end
      end
      S_INIT: begin
        for (int r = 0; r < MAX_DIM; r++) begin
          rord_d[r] = AW'(r);
        end
        k_d    = '0;
        i_d    = '0;
        p_d    = '0;
        best_d = '0;
        state_d = (n_eff == CW'(1)) ? S_DG0 : S_PVA;
      end
      // Pivot search down column k
      S_PVA: begin
        wm_ra   = addr(i_q, k_q);
        state_d = S_PVB;
      end
      S_PVB: begin
        if (mag_rd > best_q) begin
          best_d = mag_rd;
          p_d    = i_q;
        end
        if (i_q + CW'(1) == n_eff) begin
          state_d = S_PVE;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_PVA;
        end
      end
      S_PVE: begin
        if (best_q == '0) begin
          state_d = S_SING;
        end else if (p_q != k_q) begin
          state_d = S_RS0;
        end else begin
          i_d     = k_q + CW'(1);
          state_d = S_EL0;
        end
      end
      // Row order swap
      S_RS0: begin
        rtmp_d  = rord_q[p_q[AW-1:0]];
        state_d = S_RS1;
      end
      S_RS1: begin
        rord_d[p_q[AW-1:0]] = rord_q[k_q[AW-1:0]];
        rord_d[k_q[AW-1:0]] = rtmp_q;
        j_d     = '0;
        state_d = S_SW0;
      end
      // Row swap, one column per pass
      S_SW0: begin
        wm_ra   = addr(k_q, j_q);
        state_d = S_SW1;
      end
      S_SW1: begin
        tmp_d   = wm_rd;
        wm_ra   = addr(p_q, j_q);
        state_d = S_SW2;
      end
      S_SW2: begin
        wm_we   = 1'b1;
        wm_wa   = addr(k_q, j_q);
        wm_wd   = wm_rd;
        state_d = S_SW3;
      end
      S_SW3: begin
        wm_we = 1'b1;
        wm_wa = addr(p_q, j_q);
        wm_wd = tmp_q;
        if (j_q + CW'(1) == n_eff) begin
          i_d     = k_q + CW'(1);
          state_d = S_EL0;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = S_SW0;
        end
      end
      // Multiplier for row i
      S_EL0: begin
        wm_ra   = addr(i_q, k_q);
        state_d = S_EL1;
      end
      S_EL1: begin
        tmp_d   = wm_rd;
        wm_ra   = addr(k_q, k_q);
        state_d = S_EL2;
      end
      S_EL2: begin
        div_go  = 1'b1;
        ret_d   = S_EL3;
        state_d = S_DIV;
      end
      S_EL3: begin
        wm_we   = 1'b1;
        wm_wa   = addr(i_q, k_q);
        wm_wd   = qres_q;
        lq_d    = qres_q;
        j_d     = k_q + CW'(1);
        state_d = S_UP0;
      end
      // Row update
      S_UP0: begin
        wm_ra   = addr(k_q, j_q);
        state_d = S_UP1;
      end
      S_UP1: begin
        wm_ra   = addr(i_q, j_q);
        state_d = S_UP2;
      end
      S_UP2: begin
        wm_we = 1'b1;
        ovf_d = ovf_q | sat_r.ovf;
        if (j_q + CW'(1) == n_eff) begin
          state_d = S_ELN;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = S_UP0;
        end
      end
      S_ELN: begin
        if (i_q + CW'(1) < n_eff) begin
          i_d     = i_q + CW'(1);
          state_d = S_EL0;
        end else if ({1'b0, k_q} + (CW + 1)'(2) < {1'b0, n_eff}) begin
          k_d     = k_q + CW'(1);
          i_d     = k_q + CW'(1);
          p_d     = k_q + CW'(1);
          best_d  = '0;
          state_d = S_PVA;
        end else begin
          i_d     = '0;
          state_d = S_DG0;
        end
      end
      // Diagonal check
      S_DG0: begin
        wm_ra   = addr(i_q, i_q);
        state_d = S_DG1;
      end
      S_DG1: begin
        if (wm_rd == '0) begin
          state_d = S_SING;
        end else if (i_q + CW'(1) == n_eff) begin
          k_d     = '0;
          i_d     = '0;
          state_d = S_FW0;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_DG0;
        end
      end
      // Forward substitution for column k
      S_FW0: begin
        acc_d   = (CW'(rord_q[i_q[AW-1:0]]) == k_q) ? ONE_Q : '0;
        j_d     = '0;
        state_d = S_FW1;
      end
      S_FW1: begin
        if (j_q == i_q) begin
          fv_d[i_q[AW-1:0]] = acc_q;
          if (i_q + CW'(1) == n_eff) begin
            state_d = S_BK0;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = S_FW0;
          end
        end else begin
          wm_ra   = addr(i_q, j_q);
          state_d = S_FW2;
        end
      end
      S_FW2: state_d = S_FW3;
      S_FW3: begin
        acc_d   = sat_r.val;
        ovf_d   = ovf_q | sat_r.ovf;
        j_d     = j_q + CW'(1);
        state_d = S_FW1;
      end
      // Back substitution for column k
      S_BK0: begin
        acc_d   = fv_q[i_q[AW-1:0]];
        j_d     = i_q + CW'(1);
        state_d = S_BK1;
      end
      S_BK1: begin
        if (j_q == n_eff) begin
          wm_ra   = addr(i_q, i_q);
          state_d = S_BK4;
        end else begin
          wm_ra   = addr(i_q, j_q);
          iv_ra   = addr(j_q, k_q);
          state_d = S_BK2;
        end
      end
      S_BK2: state_d = S_BK3;
      S_BK3: begin
        acc_d   = sat_r.val;
        ovf_d   = ovf_q | sat_r.ovf;
        j_d     = j_q + CW'(1);
        state_d = S_BK1;
      end
      S_BK4: begin
        div_go  = 1'b1;
        div_a   = acc_q;
        ret_d   = S_BK5;
        state_d = S_DIV;
      end
      S_BK5: begin
        iv_we = 1'b1;
        if (i_q == '0) begin
          if (k_q + CW'(1) == n_eff) begin
            j_d     = '0;
            state_d = S_OUT0;
          end else begin
            k_d     = k_q + CW'(1);
            state_d = S_FW0;
          end
        end else begin
          i_d     = i_q - CW'(1);
          state_d = S_BK0;
        end
      end
      // Shared divider, one quotient bit per cycle
      S_DIV: begin
        if (trial >= {1'b0, dsr_q}) begin
          rem_d = trial - {1'b0, dsr_q};
          dvd_d = {dvd_q[46:0], 1'b1};
        end else begin
          rem_d = trial;
          dvd_d = {dvd_q[46:0], 1'b0};
        end
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'(STEPS - 1)) begin
          state_d = S_DFIN;
        end
      end
      S_DFIN: begin
        if (!dneg_q && dvd_q > 48'h0000_7FFF_FFFF) begin
          qres_d = 32'h7FFF_FFFF;
          ovf_d  = 1'b1;
        end else if (dneg_q && dvd_q > 48'h0000_8000_0000) begin
          qres_d = 32'h8000_0000;
          ovf_d  = 1'b1;
        end else begin
          qres_d = dneg_q ? (~dvd_q[31:0] + 32'd1) : dvd_q[31:0];
        end
        state_d = ret_q;
      end
      // Readout, row-major
      S_OUT0: begin
        iv_ra   = addr(i_q, j_q);
        state_d = S_OUT1;
      end
      S_OUT1: begin
        if (j_q + CW'(1) == n_eff) begin
          j_d = '0;
          if (i_q + CW'(1) == n_eff) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = S_OUT0;
          end
        end else begin
          j_d     = j_q + CW'(1);
          state_d = S_OUT0;
        end
      end
      S_SING: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    // Divider launch: magnitudes and result sign
    if (div_go) begin
      dvd_d  = {(div_a[31] ? (~div_a + 32'd1) : div_a), 16'h0000};
      dsr_d  = div_b[31] ? (~div_b + 32'd1) : div_b;
      rem_d  = '0;
      dneg_d = div_a[31] ^ div_b[31];
      dcnt_d = '0;
    end

    // Size write discards a partial load
    if (cfg_we_i) begin
      size_d = cfg_wdata_i;
      ldr_d  = '0;
      ldc_d  = '0;
      ovf_d  = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      size_q  <= SIZE_W'(MAX_DIM);
      ldr_q   <= '0;
      ldc_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      size_q  <= size_d;
      ldr_q   <= ldr_d;
      ldc_q   <= ldc_d;
      ovf_q   <= ovf_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    i_q    <= i_d;
    j_q    <= j_d;
    p_q    <= p_d;
    best_q <= best_d;
    tmp_q  <= tmp_d;
    lq_q   <= lq_d;
    acc_q  <= acc_d;
    qres_q <= qres_d;
    rtmp_q <= rtmp_d;
    rord_q <= rord_d;
    fv_q   <= fv_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    dneg_q <= dneg_d;
    dcnt_q <= dcnt_d;
    prod_q <= prod_d;
  end

  // Result port
  assign busy            = (state_q != S_IDLE);
  assign result_valid_o  = (state_q == S_OUT1) || (state_q == S_SING);
  assign inverse_value_o = (state_q == S_SING) ? '0 : iv_rd;
  assign status_o        = (state_q == S_SING) ? ST_SINGULAR : (ovf_q ? ST_SATURATE : ST_OK);
  assign last_of_run_o   = (state_q == S_SING) ||
                           (i_q + CW'(1) == n_eff && j_q + CW'(1) == n_eff);

  // Checks
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside a run");

  a_sing_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_SINGULAR |-> last_of_run_o && inverse_value_o == '0)
    else $error("bad singular item");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_of_run_o |=> !busy) else $error("run did not end");

  a_div_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> dsr_q != '0) else $error("divide by zero pivot");

endmodule

// File: test/testbench.sv
module testbench;
  import luinv_pkg::*;

  localparam int unsigned DIM      = 8;
  localparam int unsigned LIMIT    = 3000000;
  localparam int unsigned SETTLE   = 64;

  // One expected inverse entry or status item
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic                     last;
  } inv_item_t;

  // Tracks the matrix being loaded and predicts the inverse of each full matrix
  class inverse_scoreboard;
    logic [SIZE_W-1:0]        size_reg;
    logic signed [DATA_W-1:0] mat [DIM*DIM];
    int unsigned              perm [DIM];
    logic signed [DATA_W-1:0] fwd [DIM];
    logic signed [DATA_W-1:0] inv [DIM*DIM];
    int unsigned              loaded;
    bit                       sat_hit;
    inv_item_t                expected [$];
    int unsigned              errors;

    function new();
      size_reg = SIZE_W'(DIM);
      loaded   = 0;
      sat_hit  = 0;
      errors   = 0;
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int unsigned dim_now();
      if (size_reg == 0) return 1;
      if (size_reg > DIM) return DIM;
      return size_reg;
    endfunction

    function void set_size(input logic [SIZE_W-1:0] v);
      size_reg = v;
      loaded   = 0;
      sat_hit  = 0;
    endfunction

    function logic signed [DATA_W-1:0] clamp(input longint v);
      if (v > 64'sd2147483647) begin
        sat_hit = 1;
        return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
        sat_hit = 1;
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    // Floored Q16.16 product at full width
    function longint fx_mul(input logic signed [DATA_W-1:0] a, b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> 16;
    endfunction

    // Q16.16 quotient truncated toward zero, saturated
    function logic signed [DATA_W-1:0] fx_div(input logic signed [DATA_W-1:0] a, b);
      longint num;
      num = longint'(a) * 64'sd65536;
      return clamp(num / longint'(b));
    endfunction

    function longint magnitude(input logic signed [DATA_W-1:0] v);
      longint w;
      w = v;
      return (w < 0) ? -w : w;
    endfunction

    // LUP factorization then per-column solves; 0 on a zero pivot
    function bit invert(input int unsigned n);
      int unsigned p, t;
      longint best, m, acc;
      logic signed [DATA_W-1:0] l, s, x;
      for (int unsigned i = 0; i < n; i++) perm[i] = i;
      for (int unsigned k = 0; k + 1 < n; k++) begin
        best = 0;
        p = k;
        for (int unsigned i = k; i < n; i++) begin
          m = magnitude(mat[i*DIM+k]);
          if (m > best) begin
            best = m;
            p = i;
          end
        end
        if (best == 0) return 0;
        if (p != k) begin
          t = perm[k];
          perm[k] = perm[p];
          perm[p] = t;
          for (int unsigned j = 0; j < n; j++) begin
            s = mat[k*DIM+j];
            mat[k*DIM+j] = mat[p*DIM+j];
            mat[p*DIM+j] = s;
          end
        end
        for (int unsigned i = k + 1; i < n; i++) begin
          l = fx_div(mat[i*DIM+k], mat[k*DIM+k]);
          mat[i*DIM+k] = l;
          for (int unsigned j = k + 1; j < n; j++)
            mat[i*DIM+j] = clamp(longint'(mat[i*DIM+j]) - fx_mul(l, mat[k*DIM+j]));
        end
      end
      for (int unsigned i = 0; i < n; i++)
        if (mat[i*DIM+i] == 0) return 0;
      for (int unsigned k = 0; k < n; k++) begin
        // forward substitution on the permuted identity column
        for (int unsigned i = 0; i < n; i++) begin
          acc = (perm[i] == k) ? 64'sd65536 : 64'sd0;
          for (int unsigned j = 0; j < i; j++)
            acc = clamp(acc - fx_mul(mat[i*DIM+j], fwd[j]));
          fwd[i] = clamp(acc);
        end
        // back substitution
        for (int i = int'(n) - 1; i >= 0; i--) begin
          x = fwd[i];
          for (int unsigned j = i + 1; j < n; j++)
            x = clamp(longint'(x) - fx_mul(mat[i*DIM+j], inv[j*DIM+k]));
          inv[i*DIM+k] = fx_div(x, mat[i*DIM+i]);
        end
      end
      return 1;
    endfunction

    // Accepted element request
    function void note_element(input logic signed [DATA_W-1:0] v);
      int unsigned n, total;
      inv_item_t e;
      n = dim_now();
      total = n * n;
      if (loaded >= total) loaded = 0;
      if (loaded == 0) sat_hit = 0;
      mat[(loaded / n)*DIM + (loaded % n)] = v;
      loaded++;
      if (loaded < total) return;
      loaded = 0;
      if (!invert(n)) begin
        e.value  = '0;
        e.status = ST_SINGULAR;
        e.last   = 1'b1;
        expected.push_back(e);
        return;
      end
      for (int unsigned i = 0; i < total; i++) begin
        e.value  = inv[(i / n)*DIM + (i % n)];
        e.status = sat_hit ? ST_SATURATE : ST_OK;
        e.last   = (i + 1 == total);
        expected.push_back(e);
      end
    endfunction

    task check_result(input logic signed [DATA_W-1:0] v, input logic [1:0] st,
                      input logic last);
      inv_item_t e;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result value=%h status=%0d", v, st));
        return;
      end
      e = expected.pop_front();
      if (v !== e.value)
        report($sformatf("inverse_value got %h want %h", v, e.value));
      if (st !== e.status)
        report($sformatf("status got %0d want %0d", st, e.status));
      if (last !== e.last)
        report($sformatf("last_of_run got %b want %b", last, e.last));
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [SIZE_W-1:0]        cfg_wdata_i;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] element_value_i;
  logic                     result_valid_o;
  logic signed [DATA_W-1:0] inverse_value_o;
  logic [1:0]               status_o;
  logic                     last_of_run_o;

  inverse_scoreboard sb;
  int unsigned       cycles;
  int unsigned       idle_pct;
  int unsigned       sent;
  int unsigned       cur_size;

  lup_matrix_inverse #(.MAX_DIM(DIM)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .element_value_i(element_value_i),
    .result_valid_o (result_valid_o),
    .inverse_value_o(inverse_value_o),
    .status_o       (status_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sample at the rising edge: config writes, accepted requests, results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(inverse_value_o, status_o, last_of_run_o);
      if (cfg_we_i) sb.set_size(cfg_wdata_i);
      if (start && !busy) sb.note_element(element_value_i);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Size writes only between runs, with no request pending
  task write_size(input logic [SIZE_W-1:0] v);
    start = 1'b0;
    while (busy || sb.expected.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cur_size    = (v == 0) ? 1 : ((v > DIM) ? DIM : v);
  endtask

  // Drive one element; start stays high into the next request unless a gap is drawn
  task send_element(input logic signed [DATA_W-1:0] v);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start = 1'b1;
    element_value_i = v;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    sent++;
  endtask

  task finish_burst();
    start = 1'b0;
  endtask

  // Wait until every expected result has come, then let the block settle
  task drain();
    finish_burst();
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_element(input int kind, input int r,
                                                            input int c, input int n);
    logic signed [DATA_W-1:0] v;
    case (kind)
      0: begin
        // diagonally dominant, well conditioned
        if (r == c) begin
          v = ((n + $urandom_range(1, 8)) <<< 16) + $urandom_range(0, 65535);
          if ($urandom_range(1)) v = -v;
        end else begin
          v = $signed($urandom_range(0, 131072)) - 65536;
        end
      end
      1: v = $signed($urandom_range(0, 524288)) - 262144;
      2: v = $urandom;
      3: v = (c == 0) ? 32'sd0 : $signed($urandom_range(0, 262144)) - 131072;
      default: begin
        case ($urandom_range(5))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 32'sd0;
          3: v = 32'sd1;
          4: v = -32'sd1;
          default: v = 32'sd65536;
        endcase
      end
    endcase
    return v;
  endfunction

  task send_matrix(input int kind);
    for (int r = 0; r < int'(cur_size); r++)
      for (int c = 0; c < int'(cur_size); c++)
        send_element(pick_element(kind, r, c, cur_size));
  endtask

  int unsigned phase_start;
  int unsigned kind_draw;
  int unsigned sz_draw;

  initial begin
    sb              = new();
    cycles          = 0;
    sent            = 0;
    idle_pct        = 0;
    cur_size        = DIM;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    start           = 1'b0;
    element_value_i = '0;
    rst_ni          = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Size zero acts as one: one, zero pivot, most negative, saturating quotient
    write_size(4'd0);
    send_element(32'sd65536);
    send_element(32'sd0);
    send_element(32'sh8000_0000);
    send_element(32'sd1);
    drain();
    write_size(4'd1);
    send_element(32'sh7FFF_FFFF);
    send_element(-32'sd1);
    drain();

    // 2x2: row swap, tie in magnitude keeps first row, zero final pivot
    write_size(4'd2);
    send_element(32'sd0);       send_element(32'sd65536);
    send_element(32'sd65536);   send_element(32'sd0);
    send_element(-32'sd131072); send_element(32'sd65536);
    send_element(32'sd131072);  send_element(32'sd196608);
    send_element(32'sd65536);   send_element(32'sd131072);
    send_element(32'sd131072);  send_element(32'sd262144);
    drain();

    // Partly loaded matrix discarded by a config write, oversize acts as max
    send_element(32'sd65536);
    send_element(32'sd7);
    drain();
    write_size(4'd15);
    send_element(32'sd65536);
    send_element(32'sd3);
    drain();
    write_size(4'd3);
    send_matrix(0);
    drain();

    // Random runs across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 67;
        2: idle_pct = 0;
        default: idle_pct = 9;
      endcase
      write_size(SIZE_W'($urandom_range(1, 4)));
      phase_start = sent;
      while (sent - phase_start < 100) begin
        if ($urandom_range(99) < 30) begin
          sz_draw = $urandom_range(99);
          if (sz_draw < 6) write_size(SIZE_W'(DIM));
          else if (sz_draw < 10) write_size(SIZE_W'($urandom_range(9, 15)));
          else if (sz_draw < 14) write_size(4'd0);
          else if (sz_draw < 22) write_size(SIZE_W'($urandom_range(5, 7)));
          else write_size(SIZE_W'($urandom_range(1, 4)));
        end
        kind_draw = $urandom_range(99);
        if (kind_draw < 55) send_matrix(0);
        else if (kind_draw < 70) send_matrix(1);
        else if (kind_draw < 82) send_matrix(2);
        else if (kind_draw < 91) send_matrix(3);
        else send_matrix(4);
        // sometimes keep start high straight into the next matrix
        if ($urandom_range(1)) drain();
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
